[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/ncc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Types, codes and helpers for the nearest-color classifier pipeline.
// ----------------------------------------------------------------------------
package ncc_pkg;

    typedef logic [7:0]  level_t;
    typedef logic [9:0]  score_t;
    typedef logic [23:0] rgb_ref_t;
    typedef logic [2:0]  class_t;
    typedef logic [4:0]  mask_t;

    // result codes
    localparam class_t CLASS_NONE  = 3'd0;
    localparam class_t CLASS_RED   = 3'd1;
    localparam class_t CLASS_GREEN = 3'd2;
    localparam class_t CLASS_BLUE  = 3'd3;
    localparam class_t CLASS_WHITE = 3'd4;
    localparam class_t CLASS_BLACK = 3'd5;

    localparam int NUM_RGB  = 3;
    localparam int NUM_CAND = 5;

    // candidate slot -> result code, slot order is the tie-break priority
    localparam class_t [NUM_CAND-1:0] CAND_CLASS =
        {CLASS_BLACK, CLASS_WHITE, CLASS_BLUE, CLASS_GREEN, CLASS_RED};

    localparam int CAND_WHITE = 3;
    localparam int CAND_BLACK = 4;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_RED_REF   = 2'd0;
    localparam cfg_index_t REG_GREEN_REF = 2'd1;
    localparam cfg_index_t REG_BLUE_REF  = 2'd2;
    localparam cfg_index_t REG_BRIGHT    = 2'd3;

    localparam rgb_ref_t RED_REF_RST   = 24'h4B0E19;
    localparam rgb_ref_t GREEN_REF_RST = 24'h0D332B;
    localparam rgb_ref_t BLUE_REF_RST  = 24'h0D2637;
    localparam level_t   BRIGHT_RST    = 8'd200;

    localparam score_t FAR_SCORE = 10'd255;

    typedef struct packed {
        logic [NUM_RGB-1:0][23:0] color_ref;   // [0] red, [1] green, [2] blue
        level_t                   bright_threshold;
    } ncc_cfg_t;

    typedef struct packed {
        level_t red_level;
        level_t green_level;
        level_t blue_level;
        level_t ambient_level;
        mask_t  search_mask;
    } ncc_sample_t;

    // stage 1: per-component absolute differences, [color][component]
    typedef struct packed {
        logic [NUM_RGB-1:0][2:0][7:0] diff;
        logic                         bright;
        mask_t                        mask;
    } ncc_diff_t;

    // stage 2: one score per candidate
    typedef struct packed {
        score_t [NUM_CAND-1:0] score;
        mask_t                 mask;
    } ncc_score_t;

    function automatic level_t abs_diff(input level_t a, input level_t b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[sv/ncc_diff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_diff
// Stage 1: absolute component differences against each reference, brightness
// flag, and masking of invalid samples.
// ----------------------------------------------------------------------------
module ncc_diff (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ncc_pkg::ncc_sample_t in_sample,
    input  ncc_pkg::ncc_cfg_t   cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output ncc_pkg::ncc_diff_t  out_data
);

    logic               valid_reg;
    ncc_pkg::ncc_diff_t data_reg;
    ncc_pkg::ncc_diff_t data_next;
    logic               advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        for (int c = 0; c < ncc_pkg::NUM_RGB; c++) begin
            data_next.diff[c][0] = ncc_pkg::abs_diff(in_sample.red_level,
                                                     cfg.color_ref[c][23:16]);
            data_next.diff[c][1] = ncc_pkg::abs_diff(in_sample.green_level,
                                                     cfg.color_ref[c][15:8]);
            data_next.diff[c][2] = ncc_pkg::abs_diff(in_sample.blue_level,
                                                     cfg.color_ref[c][7:0]);
        end
        data_next.bright = in_sample.ambient_level > cfg.bright_threshold;
        // zero ambient means no sample: drop every candidate
        data_next.mask   = (in_sample.ambient_level == '0) ? '0 : in_sample.search_mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/ncc_score.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_score
// Stage 2: L1 sums for the RGB candidates, fixed scores for white and black.
// ----------------------------------------------------------------------------
module ncc_score (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ncc_pkg::ncc_diff_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ncc_pkg::ncc_score_t out_data
);

    logic                valid_reg;
    ncc_pkg::ncc_score_t data_reg;
    ncc_pkg::ncc_score_t data_next;
    logic                advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        for (int c = 0; c < ncc_pkg::NUM_RGB; c++) begin
            data_next.score[c] = 10'(in_data.diff[c][0]) + 10'(in_data.diff[c][1])
                               + 10'(in_data.diff[c][2]);
        end
        data_next.score[ncc_pkg::CAND_WHITE] = in_data.bright ? '0 : ncc_pkg::FAR_SCORE;
        data_next.score[ncc_pkg::CAND_BLACK] = in_data.bright ? ncc_pkg::FAR_SCORE : '0;
        data_next.mask = in_data.mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/ncc_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_select
// Stage 3: lowest-score search over the enabled candidates, into the output
// register. Strictly-lower compare keeps the earlier candidate on a tie.
// ----------------------------------------------------------------------------
module ncc_select (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ncc_pkg::ncc_score_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ncc_pkg::class_t     out_class
);

    logic             valid_reg;
    ncc_pkg::class_t  class_reg;
    ncc_pkg::class_t  class_next;
    ncc_pkg::score_t  best;
    logic             advance;

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_class = class_reg;

    always_comb begin
        class_next = ncc_pkg::CLASS_NONE;
        best       = '0;
        for (int k = 0; k < ncc_pkg::NUM_CAND; k++) begin
            if (in_data.mask[k] &&
                (class_next == ncc_pkg::CLASS_NONE || in_data.score[k] < best)) begin
                best       = in_data.score[k];
                class_next = ncc_pkg::CAND_CLASS[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            class_reg <= class_next;
        end
    end

endmodule

[sv/rgb_nearest_color_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_nearest_color_classifier
// Classifies an RGB + ambient sample as none/red/green/blue/white/black.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_valid/s_ready): red, green, blue and ambient levels plus a
//   5-bit candidate mask. Result beat (m_valid/m_ready): one 3-bit class per
//   input beat, in order.
//   Three register stages: differences, scores, min-search + output register.
//   Throughput is one beat per cycle while m_ready is high, bounded by the
//   three stage registers. Each stage advances when it is empty or its
//   successor takes its beat, so s_ready stays high while bubbles remain even
//   if m_ready is low; once all three stages hold beats, s_ready drops until
//   m_ready returns. Nothing is dropped or duplicated under stall.
//   Config: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 red ref, 1 green ref, 2 blue ref, 3 bright threshold in bits 7:0).
//   Write only while the pipeline is empty.
//   Reset (aresetn low, synchronous): pipeline empties and the references
//   and threshold return to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_nearest_color_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_level,
    input  logic [7:0]  s_green_level,
    input  logic [7:0]  s_blue_level,
    input  logic [7:0]  s_ambient_level,
    input  logic [4:0]  s_search_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_color_class
);

    ncc_pkg::ncc_cfg_t   cfg_reg;
    ncc_pkg::ncc_sample_t sample;
    ncc_pkg::ncc_diff_t  diff_data;
    ncc_pkg::ncc_score_t score_data;
    logic                diff_valid;
    logic                diff_ready;
    logic                score_valid;
    logic                score_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_ref[0]    <= ncc_pkg::RED_REF_RST;
            cfg_reg.color_ref[1]    <= ncc_pkg::GREEN_REF_RST;
            cfg_reg.color_ref[2]    <= ncc_pkg::BLUE_REF_RST;
            cfg_reg.bright_threshold <= ncc_pkg::BRIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ncc_pkg::REG_RED_REF:   cfg_reg.color_ref[0] <= cfg_wdata;
                ncc_pkg::REG_GREEN_REF: cfg_reg.color_ref[1] <= cfg_wdata;
                ncc_pkg::REG_BLUE_REF:  cfg_reg.color_ref[2] <= cfg_wdata;
                ncc_pkg::REG_BRIGHT:    cfg_reg.bright_threshold <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign sample.red_level     = s_red_level;
    assign sample.green_level   = s_green_level;
    assign sample.blue_level    = s_blue_level;
    assign sample.ambient_level = s_ambient_level;
    assign sample.search_mask   = s_search_mask;

    ncc_diff u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (sample),
        .cfg       (cfg_reg),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_data  (diff_data)
    );

    ncc_score u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_data   (diff_data),
        .out_valid (score_valid),
        .out_ready (score_ready),
        .out_data  (score_data)
    );

    ncc_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (score_valid),
        .in_ready  (score_ready),
        .in_data   (score_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_class (m_color_class)
    );

    // no-sample beat must reach stage 1 with every candidate dropped
    `ASSERT_CLK_RST(a_dark_masked, aclk, aresetn, (s_valid && s_ready && s_ambient_level == 8'd0) |=> (diff_valid && diff_data.mask == 5'd0), "zero-ambient beat kept candidates")
    // white and black scores are always complementary
    `ASSERT_CLK_RST(a_wb_complement, aclk, aresetn, score_valid |-> ((score_data.score[ncc_pkg::CAND_WHITE] == 10'd0) != (score_data.score[ncc_pkg::CAND_BLACK] == 10'd0)), "white/black scores not complementary")
    // result code stays within the defined classes
    `ASSERT_CLK_RST(a_class_range, aclk, aresetn, m_valid |-> (m_color_class <= ncc_pkg::CLASS_BLACK), "class code out of range")
    // pipeline is empty right after reset
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> (!m_valid && !diff_valid && !score_valid), "pipeline not empty after reset")

endmodule
